### hdl/afrx_pkg.sv
// Shared types and constants for the addressed frame receiver.
package afrx_pkg;

   // Smallest legal value of the length byte (length, dest, src, cmd, check).
   localparam logic [7:0] MIN_LENGTH = 8'd5;

   // Input item kinds.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_GAP  = 1'b1;

   // Configuration register indexes.
   localparam logic [7:0] CSR_NODE_ADDRESS = 8'd0;
   localparam logic [7:0] CSR_START_BYTE   = 8'd1;

   // Receive phases of the frame parser.
   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN,
      PH_DEST,
      PH_SRC,
      PH_CMD,
      PH_DATA,
      PH_BCC
   } phase_type;

   // States of the result sequencer.
   typedef enum logic [1:0] {
      EM_IDLE,
      EM_READ,
      EM_SHOW
   } emit_state_type;

   // One input item.
   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [7:0] source_addr;
      logic [7:0] command_code;
      logic [4:0] payload_len;
      logic [3:0] byte_pos;
      logic [7:0] payload_byte;
      logic       truncated;
      logic       last;
   } rsp_type;

   // Summary of a good frame handed from the parser to the sequencer.
   typedef struct packed {
      logic [7:0] source_addr;
      logic [7:0] command_code;
      logic [7:0] stored_len;
      logic       truncated;
   } frame_info_type;

endpackage

### hdl/addressed_frame_receiver_xor_check_core.sv
// Addressed frame receiver with XOR block check: top level with configuration registers.
// Input: one item per cycle while no result run is playing out; req_stall is high during a run.
// After the check byte is accepted, the sequencer does one memory read (EM_READ), then raises rsp_valid (EM_SHOW).
// Each result takes a memory read, then is shown in EM_SHOW until it is taken despite rsp_stall.
// A good frame with n stored bytes therefore holds the input until all max(n,1) results are taken.
// Reset is synchronous and clears all control state; the payload memory is not cleared.
module addressed_frame_receiver_xor_check_core #(
   parameter int MAX_PAYLOAD = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  afrx_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output afrx_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import afrx_pkg::*;

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [7:0]     node_address_ff;
   logic [7:0]     start_byte_ff;
   logic           busy;
   logic           item_fire;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [7:0]     wr_data;
   logic           frame_start;
   frame_info_type frame_info;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign item_fire = req_valid && !req_stall;

   // Configuration registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff <= 8'd1;
         start_byte_ff   <= 8'd2;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_NODE_ADDRESS) node_address_ff <= csr_wdata;
         if (csr_index == CSR_START_BYTE)   start_byte_ff   <= csr_wdata;
      end
   end

   afrx_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .item_fire    (item_fire),
      .item         (req_payload),
      .node_address (node_address_ff),
      .start_byte   (start_byte_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .frame_start  (frame_start),
      .frame_info   (frame_info)
   );

   afrx_result_seq #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW)
   ) u_result_seq (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .frame_start (frame_start),
      .frame_info  (frame_info),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### hdl/afrx_parser.sv
// Frame parser: hunts for the start byte, checks the header and XOR, writes data bytes.
module afrx_parser #(
   parameter int MAX_PAYLOAD = 16,
   parameter int AW          = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_fire,
   input  afrx_pkg::req_type        item,
   input  logic [7:0]               node_address,
   input  logic [7:0]               start_byte,
   output logic                     wr_en,
   output logic [AW-1:0]            wr_addr,
   output logic [7:0]               wr_data,
   output logic                     frame_start,
   output afrx_pkg::frame_info_type frame_info
);
   import afrx_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] bytes_seen_ff, bytes_seen_in;
   logic [7:0] xor_accum_ff, xor_accum_in;
   logic [7:0] held_source_ff, held_source_in;
   logic [7:0] held_command_ff, held_command_in;

   logic [7:0] b;
   logic [7:0] seen_next;
   logic [7:0] data_count;
   logic       is_gap;

   assign b          = item.rx_byte;
   assign is_gap     = (item.cmd == CMD_GAP);
   assign seen_next  = bytes_seen_ff + 8'd1;
   assign data_count = frame_length_ff - MIN_LENGTH;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (item_fire) begin
         if (is_gap) begin
            phase_in = PH_HUNT;
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  if (b == start_byte) phase_in = PH_LEN;
               end
               PH_LEN: begin
                  phase_in = (b < MIN_LENGTH) ? PH_HUNT : PH_DEST;
               end
               PH_DEST: begin
                  phase_in = (b != node_address) ? PH_HUNT : PH_SRC;
               end
               PH_SRC: begin
                  phase_in = PH_CMD;
               end
               PH_CMD: begin
                  phase_in = (frame_length_ff == MIN_LENGTH) ? PH_BCC : PH_DATA;
               end
               PH_DATA: begin
                  if (seen_next >= data_count) phase_in = PH_BCC;
               end
               PH_BCC: begin
                  phase_in = PH_HUNT;
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

   // Datapath updates, payload writes and the frame start pulse.
   always_comb begin
      frame_length_in = frame_length_ff;
      bytes_seen_in   = bytes_seen_ff;
      xor_accum_in    = xor_accum_ff;
      held_source_in  = held_source_ff;
      held_command_in = held_command_ff;
      wr_en           = 1'b0;
      wr_addr         = bytes_seen_ff[AW-1:0];
      wr_data         = b;
      frame_start     = 1'b0;
      if (item_fire && !is_gap) begin
         case (phase_ff)
            PH_HUNT: begin
               if (b == start_byte) begin
                  xor_accum_in  = b;
                  bytes_seen_in = 8'd0;
               end
            end
            PH_LEN: begin
               if (b >= MIN_LENGTH) begin
                  frame_length_in = b;
                  xor_accum_in    = xor_accum_ff ^ b;
               end
            end
            PH_DEST: begin
               if (b == node_address) xor_accum_in = xor_accum_ff ^ b;
            end
            PH_SRC: begin
               held_source_in = b;
               xor_accum_in   = xor_accum_ff ^ b;
            end
            PH_CMD: begin
               held_command_in = b;
               xor_accum_in    = xor_accum_ff ^ b;
               bytes_seen_in   = 8'd0;
            end
            PH_DATA: begin
               wr_en         = (bytes_seen_ff < 8'(MAX_PAYLOAD));
               xor_accum_in  = xor_accum_ff ^ b;
               bytes_seen_in = seen_next;
            end
            PH_BCC: begin
               frame_start = (b == xor_accum_ff);
            end
            default: begin
               frame_start = 1'b0;
            end
         endcase
      end
   end

   // Summary of the frame for the result sequencer; excess data saturates.
   always_comb begin
      frame_info.source_addr  = held_source_ff;
      frame_info.command_code = held_command_ff;
      frame_info.truncated    = (data_count > 8'(MAX_PAYLOAD));
      frame_info.stored_len   = frame_info.truncated ? 8'(MAX_PAYLOAD) : data_count;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         frame_length_ff <= 8'd0;
         bytes_seen_ff   <= 8'd0;
         xor_accum_ff    <= 8'd0;
         held_source_ff  <= 8'd0;
         held_command_ff <= 8'd0;
      end else begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         bytes_seen_ff   <= bytes_seen_in;
         xor_accum_ff    <= xor_accum_in;
         held_source_ff  <= held_source_in;
         held_command_ff <= held_command_in;
      end
   end

endmodule

### hdl/afrx_result_seq.sv
// Payload memory and the sequencer that plays a good frame out as a run of result items.
module afrx_result_seq #(
   parameter int MAX_PAYLOAD = 16,
   parameter int AW          = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     frame_start,
   input  afrx_pkg::frame_info_type frame_info,
   output logic                     busy,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output afrx_pkg::rsp_type        rsp_payload
);
   import afrx_pkg::*;

   logic [7:0] mem [0:MAX_PAYLOAD-1];

   emit_state_type state_ff, state_in;
   frame_info_type info_ff;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [7:0]     rdata_ff;
   logic [7:0]     last_pos;
   logic           is_last;
   logic           rsp_fire;

   assign rsp_fire = rsp_valid && !rsp_stall;
   assign last_pos = (info_ff.stored_len == 8'd0) ? 8'd0 : info_ff.stored_len - 8'd1;
   assign is_last  = (8'(pos_ff) == last_pos);

   // Payload memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (state_ff == EM_READ) rdata_ff <= mem[pos_ff];
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      case (state_ff)
         EM_IDLE: begin
            if (frame_start) begin
               state_in = EM_READ;
               pos_in   = '0;
            end
         end
         EM_READ: begin
            state_in = EM_SHOW;
         end
         EM_SHOW: begin
            if (rsp_fire) begin
               if (is_last) begin
                  state_in = EM_IDLE;
               end else begin
                  state_in = EM_READ;
                  pos_in   = pos_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      busy                     = (state_ff != EM_IDLE);
      rsp_valid                = (state_ff == EM_SHOW);
      rsp_payload.source_addr  = info_ff.source_addr;
      rsp_payload.command_code = info_ff.command_code;
      rsp_payload.payload_len  = info_ff.stored_len[4:0];
      rsp_payload.byte_pos     = 4'(pos_ff);
      rsp_payload.payload_byte = (info_ff.stored_len == 8'd0) ? 8'd0 : rdata_ff;
      rsp_payload.truncated    = info_ff.truncated;
      rsp_payload.last         = is_last;
   end

   // Control registers; the frame summary is captured as the run starts.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
      if (state_ff == EM_IDLE && frame_start) info_ff <= frame_info;
   end

   // A new frame never arrives while a run is still playing out.
   assert property (@(posedge clock) disable iff (reset)
      frame_start |-> state_ff == EM_IDLE)
      else $error("frame start while a run is in progress");

   // No payload write lands while the memory is being read out.
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en)
      else $error("payload write during a result run");

   // Taking the last item ends the run; taking any other fetches the next byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_payload.last) |=> state_ff == EM_IDLE)
      else $error("run did not end after its last item");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_payload.last) |=> state_ff == EM_READ && pos_ff == $past(pos_ff) + 1'b1)
      else $error("run did not advance to the next byte");

endmodule

### tb/tb_addressed_frame_receiver_xor_check_core.sv
// Self-checking testbench for the addressed frame receiver with XOR block check.
`timescale 1ns / 100ps

module tb_addressed_frame_receiver_xor_check_core;
   import afrx_pkg::*;

   localparam int PAYLOAD_DEPTH = 16;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 40;

   // Tracks the parser state and queues the results each accepted item should produce.
   class frame_scoreboard;
      logic [7:0] node_address;
      logic [7:0] start_byte;
      phase_type  phase;
      logic [7:0] frame_length;
      logic [7:0] data_count;
      logic [7:0] xor_accum;
      logic [7:0] held_source;
      logic [7:0] held_command;
      logic [7:0] payload_store [PAYLOAD_DEPTH];
      rsp_type    pending_results [$];
      int         mismatch_count;

      function new();
         node_address   = 8'd1;
         start_byte     = 8'd2;
         phase          = PH_HUNT;
         frame_length   = 8'd0;
         data_count     = 8'd0;
         xor_accum      = 8'd0;
         held_source    = 8'd0;
         held_command   = 8'd0;
         mismatch_count = 0;
      endfunction

      // Register writes to unknown indexes leave the configuration alone.
      function void apply_register(logic [7:0] index, logic [7:0] value);
         if (index == CSR_NODE_ADDRESS) begin
            node_address = value;
         end else if (index == CSR_START_BYTE) begin
            start_byte = value;
         end
      endfunction

      // Advances the parser by one accepted item and queues any frame results.
      function void note_rx_item(req_type item);
         logic [7:0] b;
         int         stored;
         int         runs;
         logic       trunc;
         rsp_type    r;
         b = item.rx_byte;
         if (item.cmd == CMD_GAP) begin
            phase = PH_HUNT;
            return;
         end
         case (phase)
            PH_HUNT: begin
               if (b == start_byte) begin
                  xor_accum  = b;
                  data_count = 8'd0;
                  phase      = PH_LEN;
               end
            end
            PH_LEN: begin
               if (b < MIN_LENGTH) begin
                  phase = PH_HUNT;
               end else begin
                  frame_length = b;
                  xor_accum    = xor_accum ^ b;
                  phase        = PH_DEST;
               end
            end
            PH_DEST: begin
               if (b != node_address) begin
                  phase = PH_HUNT;
               end else begin
                  xor_accum = xor_accum ^ b;
                  phase     = PH_SRC;
               end
            end
            PH_SRC: begin
               held_source = b;
               xor_accum   = xor_accum ^ b;
               phase       = PH_CMD;
            end
            PH_CMD: begin
               held_command = b;
               xor_accum    = xor_accum ^ b;
               data_count   = 8'd0;
               phase        = (frame_length == MIN_LENGTH) ? PH_BCC : PH_DATA;
            end
            PH_DATA: begin
               // Bytes past the store still count toward the check byte.
               if (data_count < PAYLOAD_DEPTH) begin
                  payload_store[data_count] = b;
               end
               xor_accum  = xor_accum ^ b;
               data_count = data_count + 8'd1;
               if (data_count >= frame_length - MIN_LENGTH) begin
                  phase = PH_BCC;
               end
            end
            PH_BCC: begin
               phase = PH_HUNT;
               if (b == xor_accum) begin
                  stored = frame_length - MIN_LENGTH;
                  trunc  = (stored > PAYLOAD_DEPTH);
                  if (trunc) begin
                     stored = PAYLOAD_DEPTH;
                  end
                  // An empty payload still yields one result carrying a zero byte.
                  runs = (stored == 0) ? 1 : stored;
                  for (int k = 0; k < runs; k++) begin
                     r.source_addr  = held_source;
                     r.command_code = held_command;
                     r.payload_len  = 5'(stored);
                     r.byte_pos     = 4'(k);
                     r.payload_byte = (stored == 0) ? 8'h00 : payload_store[k];
                     r.truncated    = trunc;
                     r.last         = (k == runs - 1);
                     pending_results.push_back(r);
                  end
               end
            end
            default: begin
               phase = PH_HUNT;
            end
         endcase
      endfunction

      function void report_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
         end
      endfunction

      // Compares one accepted result with the oldest expected one.
      function void match_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            mismatch_count++;
            return;
         end
         want = pending_results.pop_front();
         report_field("source_addr", want.source_addr, got.source_addr);
         report_field("command_code", want.command_code, got.command_code);
         report_field("payload_len", 8'(want.payload_len), 8'(got.payload_len));
         report_field("byte_pos", 8'(want.byte_pos), 8'(got.byte_pos));
         report_field("payload_byte", want.payload_byte, got.payload_byte);
         report_field("truncated", 8'(want.truncated), 8'(got.truncated));
         report_field("last", 8'(want.last), 8'(got.last));
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   logic [7:0] csr_index;
   logic [7:0] csr_wdata;

   frame_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   bit hold_request;

   addressed_frame_receiver_xor_check_core #(
      .MAX_PAYLOAD(PAYLOAD_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offers one item, with random idle cycles ahead of it, and waits until it is taken.
   task automatic send_item(logic kind, logic [7:0] value);
      req_type item;
      item = '{cmd: kind, rx_byte: value};
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      sb.note_rx_item(item);
      items_sent++;
   endtask

   // Sends a frame with a computed check byte; stop_at cuts it short, optionally with a gap.
   task automatic send_frame(logic [7:0] len, logic [7:0] dest, logic [7:0] src,
                             logic [7:0] code, logic [7:0] data_q[$],
                             logic [7:0] check_flip, int stop_at, bit gap_at_stop);
      logic [7:0] bytes_q [$];
      logic [7:0] check;
      bytes_q = {sb.start_byte, len, dest, src, code};
      foreach (data_q[k]) bytes_q.push_back(data_q[k]);
      check = 8'h00;
      foreach (bytes_q[k]) check = check ^ bytes_q[k];
      bytes_q.push_back(check ^ check_flip);
      foreach (bytes_q[k]) begin
         if (k == stop_at) begin
            if (gap_at_stop) begin
               send_item(CMD_GAP, 8'($urandom));
            end
            break;
         end
         send_item(CMD_BYTE, bytes_q[k]);
      end
   endtask

   // Mostly good frames with random content; the rest are damaged frames or line noise.
   task automatic send_random_frame();
      logic [7:0] data_q [$];
      logic [7:0] len;
      logic [7:0] dest;
      logic [7:0] flip;
      int         n_data;
      int         flavor;
      int         stop_at;
      if ($urandom_range(9) == 0) begin
         n_data = $urandom_range(PAYLOAD_DEPTH + 8, PAYLOAD_DEPTH + 1);
      end else begin
         n_data = $urandom_range(PAYLOAD_DEPTH, 0);
      end
      repeat (n_data) data_q.push_back(8'($urandom));
      len     = 8'(n_data + 5);
      dest    = sb.node_address;
      flip    = 8'h00;
      stop_at = -1;
      flavor  = $urandom_range(99);
      // A leading gap usually clears whatever the last sequence left behind.
      if ($urandom_range(4) != 0) begin
         send_item(CMD_GAP, 8'($urandom));
      end
      if (flavor >= 95) begin
         repeat ($urandom_range(8, 1)) send_item(CMD_BYTE, 8'($urandom));
         return;
      end else if (flavor >= 88) begin
         stop_at = $urandom_range(n_data + 5, 1);
      end else if (flavor >= 82) begin
         len     = 8'($urandom_range(4, 0));
         stop_at = 2;
      end else if (flavor >= 74) begin
         dest = sb.node_address ^ 8'($urandom_range(255, 1));
      end else if (flavor >= 66) begin
         flip = 8'($urandom_range(255, 1));
      end
      send_frame(len, dest, 8'($urandom), 8'($urandom), data_q, flip, stop_at,
                 flavor >= 88);
   endtask

   // Writes one register; the caller lowers csr_valid after its last write.
   task automatic write_csr(logic [7:0] index, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.apply_register(index, value);
   endtask

   // Holds the sender until every expected result has come and the block has settled.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int send_pct, int recv_pct, logic [7:0] node, logic [7:0] start);
      int target;
      wait_drained();
      write_csr(CSR_NODE_ADDRESS, node);
      write_csr(CSR_START_BYTE, start);
      csr_valid     <= 1'b0;
      send_idle_pct  = send_pct;
      recv_idle_pct  = recv_pct;
      target         = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_frame();
   endtask

   // Result side: checks accepted results and stalls at random or for a long hold-off.
   initial begin : result_monitor
      int held_off;
      held_off   = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.match_result(rsp_payload);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            held_off     = HOLD_CYCLES;
         end
         if (held_off > 0) begin
            held_off--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      logic [7:0] data_q [$];
      sb            = new();
      send_idle_pct = 21;
      recv_idle_pct = 88;
      items_sent    = 0;
      hold_request  = 1'b0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset register values.
      data_q = {};
      send_frame(MIN_LENGTH, sb.node_address, 8'hFF, 8'h00, data_q, 8'h00, -1, 1'b0);
      data_q = {sb.start_byte, 8'hFF};
      send_frame(8'd7, sb.node_address, 8'h00, 8'hFF, data_q, 8'h00, -1, 1'b0);
      data_q = {};
      send_frame(MIN_LENGTH, sb.node_address, 8'h5A, 8'hA5, data_q, 8'h01, -1, 1'b0);
      send_frame(8'd4, sb.node_address, 8'h00, 8'h00, data_q, 8'h00, 2, 1'b0);
      send_frame(MIN_LENGTH, sb.node_address ^ 8'h80, 8'h00, 8'h00, data_q, 8'h00, 3, 1'b0);
      data_q = {8'h11, 8'h22, 8'h33};
      send_frame(8'd8, sb.node_address, 8'h3C, 8'hC3, data_q, 8'h00, 3, 1'b1);

      // Random frames under several register settings and idling patterns.
      run_phase(21, 88, 8'h00, 8'hFF);
      wait_drained();
      write_csr(8'($urandom_range(255, 2)), 8'($urandom));
      csr_valid <= 1'b0;
      run_phase(88, 21, 8'hFF, 8'h00);
      wait_drained();
      write_csr(CSR_NODE_ADDRESS, 8'($urandom));
      write_csr(CSR_START_BYTE, 8'($urandom));
      csr_valid     <= 1'b0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;

      // A long receiver hold-off while frames keep coming fills the block up.
      hold_request = 1'b1;
      repeat (6) send_random_frame();

      // A frame carrying far more data than the payload store holds.
      data_q = {};
      repeat (40) data_q.push_back(8'($urandom));
      send_frame(8'd45, sb.node_address, 8'($urandom), 8'($urandom), data_q, 8'h00, -1,
                 1'b0);
      run_phase(0, 0, 8'($urandom), 8'($urandom));

      wait_drained();
      if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Guards against a hung handshake.
   initial begin : watchdog
      #(5_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
hdl/afrx_pkg.sv
hdl/afrx_parser.sv
hdl/afrx_result_seq.sv
hdl/addressed_frame_receiver_xor_check_core.sv
tb/tb_addressed_frame_receiver_xor_check_core.sv
